// ===== rtl/core/tlf_pkg.sv =====
package tlf_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int TAG_W    = 32;
   localparam int TIME_W   = 48;
   localparam int WINDOW_W = 32;
   localparam int LAPS_W   = 16;

   localparam logic [LAPS_W-1:0] LAP_MAX = {LAPS_W{1'b1}};

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] last_lap;
      logic [LAPS_W-1:0] laps;
   } tlf_entry_type;

   localparam int ENTRY_W = $bits(tlf_entry_type);

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      tlf_entry_type     wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } tlf_ram_cmd_type;

   typedef struct packed {
      logic              lap_counted;
      logic              new_tag;
      logic              table_full;
      logic [LAPS_W-1:0] laps_so_far;
      logic [TIME_W-1:0] start_time_ms;
   } tlf_result_type;

endpackage

// ===== rtl/core/tlf_req_if.sv =====
interface tlf_req_if;
   logic                        valid;
   logic                        ready;
   logic [tlf_pkg::TAG_W-1:0]   tag_id;
   logic [tlf_pkg::TIME_W-1:0]  read_time_ms;

   modport source (output valid, output tag_id, output read_time_ms, input ready);
   modport sink   (input valid, input tag_id, input read_time_ms, output ready);
endinterface

// ===== rtl/core/tlf_rsp_if.sv =====
interface tlf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        lap_counted;
   logic                        new_tag;
   logic                        table_full;
   logic [tlf_pkg::LAPS_W-1:0]  laps_so_far;
   logic [tlf_pkg::TIME_W-1:0]  start_time_ms;

   modport source (output valid, output lap_counted, output new_tag, output table_full,
                   output laps_so_far, output start_time_ms, input ready);
   modport sink   (input valid, input lap_counted, input new_tag, input table_full,
                   input laps_so_far, input start_time_ms, output ready);
endinterface

// ===== rtl/core/tlf_csr_if.sv =====
interface tlf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tlf_pkg::WINDOW_W-1:0]  window_ms;

   modport source (output valid, output window_ms, input ready);
   modport sink   (input valid, input window_ms, output ready);
endinterface

// ===== rtl/core/tag_read_lap_filter.sv =====
// Tag read lap filter: one result per tag read. Reads are handled one at a time; the
// time from a read's transfer to its result grows with the number of entries in use
// (up to 256), because the tag table sits in a single-port-read RAM that
// is scanned one entry per cycle. The result sits in an output register, so the next
// read is taken while an earlier result still waits downstream. The window register
// is written through the csr channel, which is always ready.
module tag_read_lap_filter (
   input  logic      clock,
   input  logic      reset,
   tlf_req_if.sink   req_chan,
   tlf_rsp_if.source rsp_chan,
   tlf_csr_if.sink   csr_chan
);
   import tlf_pkg::*;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tlf_result_type      rsp_ff, rsp_in;

   tlf_ram_cmd_type     ram_cmd;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic                res_valid;
   tlf_result_type      res;
   logic                res_taken;

   tlf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

   tlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .window_ms (window_ff),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res       (res),
      .res_taken (res_taken)
   );

   assign csr_chan.ready = 1'b1;
   assign window_in      = csr_chan.valid ? csr_chan.window_ms : window_ff;

   assign res_taken    = res_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_in       = res_taken ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.lap_counted   = rsp_ff.lap_counted;
   assign rsp_chan.new_tag       = rsp_ff.new_tag;
   assign rsp_chan.table_full    = rsp_ff.table_full;
   assign rsp_chan.laps_so_far   = rsp_ff.laps_so_far;
   assign rsp_chan.start_time_ms = rsp_ff.start_time_ms;

   a_full_is_dropped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.table_full |->
         !rsp_ff.lap_counted && !rsp_ff.new_tag && (rsp_ff.laps_so_far == '0))
      else $error("dropped read reports a lap or an entry");

   a_new_is_first_lap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.new_tag |->
         rsp_ff.lap_counted && (rsp_ff.laps_so_far == LAPS_W'(1)))
      else $error("new entry does not report its first lap");

   a_one_read_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second read taken while one is in progress");

   a_result_loaded_when_free : assert property (@(posedge clock) disable iff (reset)
      res_taken |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("result overwrote a pending output");
endmodule

// ===== rtl/core/tlf_ram.sv =====
module tlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/tlf_ctrl.sv =====
module tlf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   tlf_req_if.sink                       req_chan,
   input  logic [tlf_pkg::WINDOW_W-1:0]  window_ms,
   output tlf_pkg::tlf_ram_cmd_type      ram_cmd,
   input  logic [tlf_pkg::ENTRY_W-1:0]   ram_rdata,
   output logic                          res_valid,
   output tlf_pkg::tlf_result_type       res,
   input  logic                          res_taken
);
   import tlf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HIT  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   tlf_entry_type     hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   tlf_result_type    res_ff, res_in;

   tlf_entry_type     rd_entry;
   logic [TIME_W:0]   lap_limit;
   logic              lap_due;
   logic [LAPS_W-1:0] laps_next;

   assign rd_entry  = tlf_entry_type'(ram_rdata);
   // The limit carries one extra bit so that last lap plus window never wraps.
   assign lap_limit = {1'b0, hit_ff.last_lap} + {{(TIME_W + 1 - WINDOW_W){1'b0}}, window_ms};
   assign lap_due   = {1'b0, time_ff} > lap_limit;
   assign laps_next = (hit_ff.laps == LAP_MAX) ? hit_ff.laps : hit_ff.laps + 1'b1;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_FIN);
   assign res            = res_ff;

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      start_in   = start_ff;
      tag_in     = tag_ff;
      time_in    = time_ff;
      iss_in     = iss_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      res_in     = res_ff;
      ram_cmd    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               tag_in     = req_chan.tag_id;
               time_in    = req_chan.read_time_ms;
               iss_in     = '0;
               cmp_vld_in = 1'b0;
               if (used_ff == '0) begin
                  start_in = req_chan.read_time_ms;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b0;
            if (cmp_vld_ff && (rd_entry.tag == tag_ff)) begin
               hit_in     = rd_entry;
               hit_idx_in = cmp_idx_ff;
               state_in   = ST_HIT;
            end else if (iss_ff < used_ff) begin
               ram_cmd.re    = 1'b1;
               ram_cmd.raddr = iss_ff[IDX_W-1:0];
               iss_in        = iss_ff + 1'b1;
               cmp_vld_in    = 1'b1;
               cmp_idx_in    = iss_ff[IDX_W-1:0];
            end else if (!cmp_vld_ff) begin
               // Every used entry has been compared without a match.
               res_in.start_time_ms = start_ff;
               res_in.lap_counted   = 1'b0;
               res_in.new_tag       = 1'b0;
               res_in.table_full    = 1'b0;
               res_in.laps_so_far   = '0;
               if (used_ff == CNT_W'(ENTRIES)) begin
                  res_in.table_full = 1'b1;
               end else begin
                  ram_cmd.we             = 1'b1;
                  ram_cmd.waddr          = used_ff[IDX_W-1:0];
                  ram_cmd.wdata.tag      = tag_ff;
                  ram_cmd.wdata.last_lap = time_ff;
                  ram_cmd.wdata.laps     = LAPS_W'(1);
                  used_in                = used_ff + 1'b1;
                  res_in.lap_counted     = 1'b1;
                  res_in.new_tag         = 1'b1;
                  res_in.laps_so_far     = LAPS_W'(1);
               end
               state_in = ST_FIN;
            end
         end
         ST_HIT: begin
            res_in.start_time_ms = start_ff;
            res_in.new_tag       = 1'b0;
            res_in.table_full    = 1'b0;
            res_in.lap_counted   = lap_due;
            res_in.laps_so_far   = lap_due ? laps_next : hit_ff.laps;
            if (lap_due) begin
               ram_cmd.we             = 1'b1;
               ram_cmd.waddr          = hit_idx_ff;
               ram_cmd.wdata.tag      = tag_ff;
               ram_cmd.wdata.last_lap = time_ff;
               ram_cmd.wdata.laps     = laps_next;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff     <= tag_in;
      time_ff    <= time_in;
      iss_ff     <= iss_in;
      cmp_vld_ff <= cmp_vld_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      res_ff     <= res_in;
   end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import tlf_pkg::*;

   localparam int          QUIET_LIMIT     = 20000;
   localparam int          RSP_HOLD_CYCLES = 800;
   localparam int          LAP_READS       = 64;
   localparam logic [63:0] TIME_MAX64      = 64'h0000_FFFF_FFFF_FFFF;

   // Tracks the tag table the way the block should, and keeps the results it owes.
   class lap_tracker;
      logic [WINDOW_W-1:0] window;
      logic [TAG_W-1:0]    tags     [ENTRIES];
      logic [TIME_W-1:0]   last_lap [ENTRIES];
      logic [LAPS_W-1:0]   laps     [ENTRIES];
      int unsigned         used;
      logic [TIME_W-1:0]   race_start;
      tlf_result_type      pending_results [$];
      int                  errors;

      function new();
         window     = '0;
         used       = 0;
         race_start = '0;
         errors     = 0;
      endfunction

      function void set_window(logic [WINDOW_W-1:0] w);
         window = w;
      endfunction

      function void note_read(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] t);
         tlf_result_type r;
         int             idx;
         int             i;
         bit             found;
         logic [63:0]    deadline;
         r     = '0;
         found = 1'b0;
         idx   = 0;
         if (used == 0) begin
            race_start = t;
         end
         for (i = 0; i < used; i++) begin
            if (!found && tags[i] == tag) begin
               found = 1'b1;
               idx   = i;
            end
         end
         if (found) begin
            // The deadline is formed in 64 bits, so it never wraps.
            deadline = {16'd0, last_lap[idx]} + {32'd0, window};
            if ({16'd0, t} > deadline) begin
               last_lap[idx] = t;
               if (laps[idx] != LAP_MAX) begin
                  laps[idx] = laps[idx] + 1'b1;
               end
               r.lap_counted = 1'b1;
            end
            r.laps_so_far = laps[idx];
         end else if (used < ENTRIES) begin
            tags[used]     = tag;
            last_lap[used] = t;
            laps[used]     = LAPS_W'(1);
            used++;
            r.lap_counted = 1'b1;
            r.new_tag     = 1'b1;
            r.laps_so_far = LAPS_W'(1);
         end else begin
            r.table_full = 1'b1;
         end
         r.start_time_ms = race_start;
         pending_results = {pending_results, r};
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(tlf_result_type got);
         tlf_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with no read waiting, expected none, actual %p", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            compare_field("lap_counted", 64'(want.lap_counted), 64'(got.lap_counted));
            compare_field("new_tag", 64'(want.new_tag), 64'(got.new_tag));
            compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
            compare_field("laps_so_far", 64'(want.laps_so_far), 64'(got.laps_so_far));
            compare_field("start_time_ms", 64'(want.start_time_ms),
                          64'(got.start_time_ms));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_idles;
   bit   receiver_idles;
   bit   rsp_hold_due;
   int   quiet_cycles;

   lap_tracker tracker = new();

   tlf_req_if req_bus ();
   tlf_rsp_if rsp_bus ();
   tlf_csr_if csr_bus ();

   tag_read_lap_filter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin : monitor
      tlf_result_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            tracker.set_window(csr_bus.window_ms);
         end
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_read(req_bus.tag_id, req_bus.read_time_ms);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.lap_counted   = rsp_bus.lap_counted;
            got.new_tag       = rsp_bus.new_tag;
            got.table_full    = rsp_bus.table_full;
            got.laps_so_far   = rsp_bus.laps_so_far;
            got.start_time_ms = rsp_bus.start_time_ms;
            tracker.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold that backs the block up.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_due && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      logic [TIME_W-1:0] v;
      v[47:32] = 16'($urandom);
      v[31:0]  = $urandom;
      return v;
   endfunction

   // Leaves valid high on return, so a following read goes out back to back.
   task automatic send_read(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] t);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.tag_id       <= tag;
      req_bus.read_time_ms <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // The first edge lets the monitor note a read taken at the edge the sender returned on.
   task automatic drain_reads();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_window(logic [WINDOW_W-1:0] w);
      drain_reads();
      repeat (8) @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.window_ms <= w;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly reads of known tags timed around the window edge, the rest new tags and noise.
   task automatic offer_random_read();
      int                pick;
      int                idx;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] last;
      logic [63:0]       t64;
      pick = $urandom_range(0, 99);
      if (pick < 35 || tracker.used == 0) begin
         tag = $urandom;
         t64 = {16'd0, rand_time()};
      end else begin
         idx  = $urandom_range(0, tracker.used - 1);
         tag  = tracker.tags[idx];
         last = tracker.last_lap[idx];
         case ($urandom_range(0, 5))
            0: t64 = {16'd0, last} + {32'd0, tracker.window};
            1: t64 = {16'd0, last} + {32'd0, tracker.window} + 64'd1;
            2: t64 = {16'd0, last} + ({32'd0, $urandom} % ({32'd0, tracker.window} + 64'd1));
            3: t64 = {16'd0, rand_time()} % ({16'd0, last} + 64'd1);
            4: t64 = {16'd0, last} + {32'd0, tracker.window} + $urandom_range(1, 5000);
            default: t64 = {16'd0, rand_time()};
         endcase
      end
      if (t64 > TIME_MAX64) begin
         t64 = TIME_MAX64;
      end
      send_read(tag, t64[TIME_W-1:0]);
   endtask

   initial begin : stimulus
      int                  k;
      int                  ph;
      logic [WINDOW_W-1:0] phase_window [5];
      logic [TIME_W-1:0]   t_c;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.tag_id       <= '0;
      req_bus.read_time_ms <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.window_ms    <= '0;
      sender_idles         = 1'b0;
      receiver_idles       = 1'b0;
      rsp_hold_due         = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The first read into the empty table latches the race start; then one tag
      // laps on every read with the window at its reset value.
      send_read(32'h0000_0000, 48'd0);
      for (k = 1; k <= LAP_READS; k++) begin
         send_read(32'h0000_0000, TIME_W'(k));
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_read(32'h0000_0000, TIME_W'(LAP_READS));

      load_window(32'hFFFF_FFFF);
      send_read(32'h0000_0000, TIME_W'(LAP_READS) + 48'hFFFF_FFFF);
      send_read(32'h0000_0000, TIME_W'(LAP_READS) + 48'hFFFF_FFFF + 48'd1);
      send_read(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_read(32'hFFFF_FFFF, 48'd0);
      send_read(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      t_c = 48'd123456;
      send_read(32'hA5A5_5A5A, t_c);

      load_window(32'd0);
      send_read(32'hA5A5_5A5A, t_c);
      send_read(32'hA5A5_5A5A, t_c + 48'd1);

      load_window(32'd1000);
      send_read(32'hA5A5_5A5A, t_c + 48'd1001);
      send_read(32'hA5A5_5A5A, t_c + 48'd1002);
      send_read(32'hA5A5_5A5A, t_c + 48'd500);
      send_read(32'h5A5A_A5A5, 48'd1000);

      phase_window[0] = 32'd1;
      phase_window[1] = $urandom_range(500, 3000);
      phase_window[2] = 32'hFFFF_FFFF;
      phase_window[3] = $urandom;
      phase_window[4] = 32'd0;
      for (ph = 0; ph < 5; ph++) begin
         load_window(phase_window[ph]);
         sender_idles   = (ph < 4);
         receiver_idles = (ph < 4);
         if (ph == 1) begin
            rsp_hold_due = 1'b1;
         end
         repeat (200) offer_random_read();
      end

      drain_reads();
      repeat (300) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== tag_read_lap_filter.f =====
rtl/core/tlf_pkg.sv
rtl/core/tlf_req_if.sv
rtl/core/tlf_rsp_if.sv
rtl/core/tlf_csr_if.sv
rtl/core/tlf_ram.sv
rtl/core/tlf_ctrl.sv
rtl/core/tag_read_lap_filter.sv
tb/sv/tb.sv
